### design/bbr_pkg.sv
// shared constants, types and helper functions of the 3x3 box blur
`default_nettype none

package bbr_pkg;

  // default frame limits
  localparam int unsigned MAX_WIDTH_DEF  = 1024;
  localparam int unsigned MAX_HEIGHT_DEF = 1024;

  // configuration port
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned CFG_DATA_W   = 11;
  localparam int unsigned WIDTH_RESET  = 800;
  localparam int unsigned HEIGHT_RESET = 600;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1
  } cfg_reg_t;

  // pixel and result formats
  localparam int unsigned COLOR_W  = 8;
  localparam int unsigned PIX_W    = 3 * COLOR_W;
  localparam int unsigned PACKED_W = 32;
  localparam logic [COLOR_W-1:0] ALPHA = 8'hFF;

  // channel sum of nine values and its division by nine
  localparam int unsigned SUM_W       = 12;
  localparam int unsigned RECIP_W     = 13;
  localparam int unsigned RECIP_9     = 7282;
  localparam int unsigned RECIP_SHIFT = 16;

  // core pipeline depth and output queue size
  localparam int unsigned CORE_DEPTH  = 3;
  localparam int unsigned OUTQ_DEPTH  = 8;

  // one item handed to the blur core
  typedef struct packed {
    logic       valid;
    logic       have;
    logic       last;
    logic [2:0] col_use;  // left, middle, right
    logic       top_ok;
    logic       mid_ok;
    logic       bot_ok;
  } bbr_item_t;

  // one blurred result leaving the core
  typedef struct packed {
    logic                valid;
    logic                last;
    logic [PACKED_W-1:0] color;
  } bbr_result_t;

  // frame dimension as written, forced into 1..maxv
  function automatic int unsigned clamp_dim(input logic [CFG_DATA_W-1:0] v,
                                            input int unsigned maxv);
    int unsigned val;
    val = int'(v);
    if (val == 0) begin
      return 1;
    end else if (val > maxv) begin
      return maxv;
    end
    return val;
  endfunction

  // floor(s / 9) for s up to nine times 255, by reciprocal multiply
  function automatic logic [COLOR_W-1:0] div9(input logic [SUM_W-1:0] s);
    logic [SUM_W+RECIP_W-1:0] p;
    p = (SUM_W + RECIP_W)'(s) * (SUM_W + RECIP_W)'(RECIP_9);
    return p[RECIP_SHIFT +: COLOR_W];
  endfunction

endpackage

`default_nettype wire

### design/bbr_in_if.sv
// source pixel channel: valid/ready with op and colour fields
`default_nettype none

interface bbr_in_if;
  logic                         valid;
  logic                         ready;
  logic                         op;
  logic [bbr_pkg::COLOR_W-1:0]  src_red;
  logic [bbr_pkg::COLOR_W-1:0]  src_green;
  logic [bbr_pkg::COLOR_W-1:0]  src_blue;

  modport source (output valid, output op, output src_red, output src_green,
                  output src_blue, input ready);
  modport sink   (input valid, input op, input src_red, input src_green,
                  input src_blue, output ready);
endinterface

`default_nettype wire

### design/bbr_out_if.sv
// blurred pixel channel: valid/ready with packed colour and frame end
`default_nettype none

interface bbr_out_if;
  logic                          valid;
  logic                          ready;
  logic [bbr_pkg::PACKED_W-1:0]  packed_color;
  logic                          frame_end;

  modport source (output valid, output packed_color, output frame_end, input ready);
  modport sink   (input valid, input packed_color, input frame_end, output ready);
endinterface

`default_nettype wire

### design/bbr_cfg_if.sv
// configuration write channel: valid/ready with register index and data
`default_nettype none

interface bbr_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [bbr_pkg::CFG_IDX_W-1:0]   index;
  logic [bbr_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### design/box_blur_3x3_rgb_unit.sv
// top level of the streaming 3x3 rgb box blur
//
// Source pixels enter on in_if in raster order, one item per pixel (op 0);
// after the frame's last pixel, drain items (op 1) push out the last line
// and a pixel of results; drains that arrive earlier are taken and dropped.
// Each result on out_if is the 3x3 neighbourhood sum per channel divided by
// nine, packed as rgba with alpha 0xFF; frame_end marks the last one.
// cfg_if writes frame width (index 0) or height (index 1) and restarts the
// frame; it is always ready. The user must see that it is written only
// while the block is idle, which the block itself does not enforce.
// Throughput is one item per cycle while in_if ready is high; each item
// reads each line store once and, inside the frame, writes it once, and a
// column under write-back is forwarded to a read of it in the same cycle.
// Results pass line store read, window shift, sums and divide to out_if.
// Reset sets width 800 and height 600 (clamped to the maxima), clears the
// counters and empties the output queue; the line stores are not cleared.
// When the receiver stalls, results collect in an 8-entry queue and in_if
// ready falls once the queue and the items in the pipeline would fill it.
`default_nettype none

module box_blur_3x3_rgb_unit #(
  parameter int unsigned MAX_WIDTH  = bbr_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = bbr_pkg::MAX_HEIGHT_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  bbr_in_if.sink     in_if,
  bbr_out_if.source  out_if,
  bbr_cfg_if.sink    cfg_if
);

  localparam int unsigned COL_W   = $clog2(MAX_WIDTH);
  localparam int unsigned WDIM_W  = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HDIM_W  = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned ROW_W   = $clog2(MAX_HEIGHT + 2);
  localparam int unsigned QDEPTH  = bbr_pkg::OUTQ_DEPTH;
  localparam int unsigned QPTR_W  = $clog2(QDEPTH);
  localparam int unsigned QCNT_W  = $clog2(QDEPTH + 1);
  localparam int unsigned FLY_W   = $clog2(bbr_pkg::CORE_DEPTH + 1);
  localparam int unsigned QENT_W  = bbr_pkg::PACKED_W + 1;

  localparam logic [WDIM_W-1:0] W_RST = WDIM_W'(bbr_pkg::clamp_dim(
      bbr_pkg::CFG_DATA_W'(bbr_pkg::WIDTH_RESET), MAX_WIDTH));
  localparam logic [HDIM_W-1:0] H_RST = HDIM_W'(bbr_pkg::clamp_dim(
      bbr_pkg::CFG_DATA_W'(bbr_pkg::HEIGHT_RESET), MAX_HEIGHT));

  // frame size and position counters
  logic [WDIM_W-1:0]  w_r;
  logic [HDIM_W-1:0]  h_r;
  logic [COL_W-1:0]   in_col_r, in_col_nxt;
  logic [ROW_W-1:0]   in_row_r, in_row_nxt;
  logic [COL_W-1:0]   out_col_r, out_col_nxt;
  logic [ROW_W-1:0]   out_row_r, out_row_nxt;

  logic               acc;
  logic               cfg_wr;
  logic               restart;
  logic [COL_W-1:0]   col;
  logic [ROW_W-1:0]   row;
  logic [COL_W-1:0]   ocol;
  logic [ROW_W-1:0]   orow;
  logic [ROW_W-1:0]   h_row;
  logic               r_lt_h;
  logic               r_ge1;
  logic               r_ge2;
  logic               active;
  logic               have;
  logic               last_now;

  bbr_pkg::bbr_item_t   item;
  bbr_pkg::bbr_result_t res;

  // output queue and items in flight
  logic [QENT_W-1:0]  q_mem [QDEPTH];
  logic [QPTR_W-1:0]  q_wr_r;
  logic [QPTR_W-1:0]  q_rd_r;
  logic [QCNT_W-1:0]  q_cnt_r;
  logic [FLY_W-1:0]   fly_r;
  logic               push;
  logic               pop;

  assign acc    = in_if.valid && in_if.ready;
  assign cfg_wr = cfg_if.valid && cfg_if.ready;
  assign cfg_if.ready = 1'b1;

  // room for every item that may still produce a result
  assign in_if.ready = (QCNT_W + 1)'(q_cnt_r) + (QCNT_W + 1)'(fly_r) < (QCNT_W + 1)'(QDEPTH);

  // position of this item, with frame restart on out-of-range counters
  always_comb begin
    h_row   = ROW_W'(h_r);
    restart = (WDIM_W'(in_col_r) >= w_r) || (in_row_r > h_row + ROW_W'(1));
    col     = restart ? '0 : in_col_r;
    row     = restart ? '0 : in_row_r;
    ocol    = restart ? '0 : out_col_r;
    orow    = restart ? '0 : out_row_r;
    r_lt_h  = row < h_row;
    r_ge1   = row != '0;
    r_ge2   = row >= ROW_W'(2);
    active  = !(r_lt_h && in_if.op);
    have    = active && ((col == '0) ? r_ge2 : r_ge1);
    last_now = have && (orow == h_row - ROW_W'(1)) &&
               (WDIM_W'(ocol) == w_r - WDIM_W'(1));

    item.valid   = acc && active;
    item.have    = have;
    item.last    = last_now;
    item.col_use = (col == '0) ? {w_r >= WDIM_W'(2), 1'b1, 1'b0}
                               : {col >= COL_W'(2), 1'b1, 1'b1};
    item.top_ok  = r_ge2 && (row - ROW_W'(2) < h_row);
    item.mid_ok  = r_ge1 && (row - ROW_W'(1) < h_row);
    item.bot_ok  = r_lt_h;

    in_col_nxt  = col;
    in_row_nxt  = row;
    out_col_nxt = ocol;
    out_row_nxt = orow;
    if (active) begin
      if (WDIM_W'(col) + WDIM_W'(1) >= w_r) begin
        in_col_nxt = '0;
        in_row_nxt = row + ROW_W'(1);
      end else begin
        in_col_nxt = col + COL_W'(1);
      end
    end
    if (have) begin
      if (last_now) begin
        in_col_nxt  = '0;
        in_row_nxt  = '0;
        out_col_nxt = '0;
        out_row_nxt = '0;
      end else if (WDIM_W'(ocol) + WDIM_W'(1) >= w_r) begin
        out_col_nxt = '0;
        out_row_nxt = orow + ROW_W'(1);
      end else begin
        out_col_nxt = ocol + COL_W'(1);
      end
    end
  end

  // configuration registers and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r       <= W_RST;
      h_r       <= H_RST;
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
    end else if (cfg_wr) begin
      case (bbr_pkg::cfg_reg_t'(cfg_if.index))
        bbr_pkg::REG_FRAME_WIDTH: begin
          w_r       <= WDIM_W'(bbr_pkg::clamp_dim(cfg_if.data, MAX_WIDTH));
          in_col_r  <= '0;
          in_row_r  <= '0;
          out_col_r <= '0;
          out_row_r <= '0;
        end
        bbr_pkg::REG_FRAME_HEIGHT: begin
          h_r       <= HDIM_W'(bbr_pkg::clamp_dim(cfg_if.data, MAX_HEIGHT));
          in_col_r  <= '0;
          in_row_r  <= '0;
          out_col_r <= '0;
          out_row_r <= '0;
        end
        default: begin
        end
      endcase
    end else if (acc) begin
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
    end
  end

  // line stores, window and arithmetic
  bbr_blur_core #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .item_i (item),
    .addr_i (col),
    .pix_i  ({in_if.src_red, in_if.src_green, in_if.src_blue}),
    .res_o  (res)
  );

  assign push = res.valid;
  assign pop  = out_if.valid && out_if.ready;

  // output queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[q_wr_r] <= {res.last, res.color};
    end
  end

  // queue pointers and in-flight count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_wr_r  <= '0;
      q_rd_r  <= '0;
      q_cnt_r <= '0;
      fly_r   <= '0;
    end else begin
      if (push) begin
        q_wr_r <= q_wr_r + QPTR_W'(1);
      end
      if (pop) begin
        q_rd_r <= q_rd_r + QPTR_W'(1);
      end
      if (push && !pop) begin
        q_cnt_r <= q_cnt_r + QCNT_W'(1);
      end else if (pop && !push) begin
        q_cnt_r <= q_cnt_r - QCNT_W'(1);
      end
      if ((acc && have) && !push) begin
        fly_r <= fly_r + FLY_W'(1);
      end else if (push && !(acc && have)) begin
        fly_r <= fly_r - FLY_W'(1);
      end
    end
  end

  assign out_if.valid        = q_cnt_r != '0;
  assign out_if.packed_color = q_mem[q_rd_r][bbr_pkg::PACKED_W-1:0];
  assign out_if.frame_end    = q_mem[q_rd_r][bbr_pkg::PACKED_W];

  // queue never overflows
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
      push && !pop |-> q_cnt_r != QCNT_W'(QDEPTH))
    else $error("output queue overflow");

  // every result leaving the core was counted in flight
  a_fly_count: assert property (@(posedge clk) disable iff (!rst_n)
      res.valid |-> fly_r != '0)
    else $error("result without an item in flight");

  // frame end returns all counters to the frame start
  a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
      acc && last_now |=> in_col_r == '0 && in_row_r == '0 &&
                          out_col_r == '0 && out_row_r == '0)
    else $error("counters not cleared after frame end");

endmodule

`default_nettype wire

### design/bbr_blur_core.sv
// line stores, 3x3 window and per-channel sum and divide pipeline
`default_nettype none

module bbr_blur_core #(
  parameter int unsigned MAX_WIDTH = bbr_pkg::MAX_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  bbr_pkg::bbr_item_t            item_i,
  input  logic [$clog2(MAX_WIDTH)-1:0]  addr_i,
  input  logic [bbr_pkg::PIX_W-1:0]     pix_i,
  output bbr_pkg::bbr_result_t          res_o
);

  localparam int unsigned COL_W   = $clog2(MAX_WIDTH);
  localparam int unsigned PIX_W   = bbr_pkg::PIX_W;
  localparam int unsigned COLOR_W = bbr_pkg::COLOR_W;
  localparam int unsigned SUM_W   = bbr_pkg::SUM_W;

  // line stores, one entry per column
  logic [PIX_W-1:0] above_mem  [MAX_WIDTH];
  logic [PIX_W-1:0] middle_mem [MAX_WIDTH];

  // stage 1: read data and item payload
  bbr_pkg::bbr_item_t s1_r;
  logic [COL_W-1:0]   s1_addr_r;
  logic [PIX_W-1:0]   s1_pix_r;
  logic [PIX_W-1:0]   above_rd_r;
  logic [PIX_W-1:0]   middle_rd_r;
  logic               s1_wr;
  logic               fwd;

  // window rows top..bottom, columns left..right
  logic [PIX_W-1:0]   win_r [3][3];

  // stage 2 and 3
  logic               s2_have_r;
  logic               s2_last_r;
  logic [2:0]         s2_use_r;
  logic               s3_have_r;
  logic               s3_last_r;
  logic [SUM_W-1:0]   s3_sum_r [3];
  logic [SUM_W-1:0]   sum_c    [3];

  // write back happens in the cycle after the read; same column back to back is forwarded
  assign s1_wr = s1_r.valid && s1_r.bot_ok;
  assign fwd   = s1_wr && (addr_i == s1_addr_r);

  // line store read, modify and write back
  always_ff @(posedge clk) begin
    if (item_i.valid) begin
      s1_addr_r   <= addr_i;
      s1_pix_r    <= pix_i;
      above_rd_r  <= fwd ? middle_rd_r : above_mem[addr_i];
      middle_rd_r <= fwd ? s1_pix_r : middle_mem[addr_i];
    end
    if (s1_wr) begin
      above_mem[s1_addr_r]  <= middle_rd_r;
      middle_mem[s1_addr_r] <= s1_pix_r;
    end
  end

  // window shift with border masking of the new column
  always_ff @(posedge clk) begin
    if (s1_r.valid) begin
      for (int i = 0; i < 3; i++) begin
        win_r[i][0] <= win_r[i][1];
        win_r[i][1] <= win_r[i][2];
      end
      win_r[0][2] <= s1_r.top_ok ? above_rd_r  : '0;
      win_r[1][2] <= s1_r.mid_ok ? middle_rd_r : '0;
      win_r[2][2] <= s1_r.bot_ok ? s1_pix_r    : '0;
    end
  end

  // column-masked channel sums over the window
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sum_c[k] = '0;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          if (s2_use_r[2-j]) begin
            sum_c[k] = sum_c[k] + SUM_W'(win_r[i][j][COLOR_W*(2-k) +: COLOR_W]);
          end
        end
      end
    end
  end

  // pipeline control and sum registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r      <= '0;
      s2_have_r <= 1'b0;
      s3_have_r <= 1'b0;
    end else begin
      s1_r      <= item_i;
      s2_have_r <= s1_r.valid && s1_r.have;
      s3_have_r <= s2_have_r;
    end
    s2_last_r <= s1_r.last;
    s2_use_r  <= s1_r.col_use;
    s3_last_r <= s2_last_r;
    s3_sum_r  <= sum_c;
  end

  // divide by nine and pack as rgba
  assign res_o.valid = s3_have_r;
  assign res_o.last  = s3_last_r;
  assign res_o.color = {bbr_pkg::div9(s3_sum_r[0]), bbr_pkg::div9(s3_sum_r[1]),
                        bbr_pkg::div9(s3_sum_r[2]), bbr_pkg::ALPHA};

endmodule

`default_nettype wire

### tb/box_blur_3x3_rgb_unit_tb.sv
// self-checking testbench for the streaming 3x3 rgb box blur unit
module box_blur_3x3_rgb_unit_tb;
  import bbr_pkg::*;

  // item codes and run limits
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 1_500_000;
  localparam int unsigned SETTLE_CYCLES = 10;
  localparam int unsigned LONG_STALL = 400;
  localparam int unsigned RANDOM_ITEMS = 500;

  typedef struct packed {
    logic               op;
    logic [PIX_W-1:0]   pix;
  } src_item_t;

  typedef struct packed {
    logic [PACKED_W-1:0] color;
    logic                last;
  } blurred_t;

  logic clk = 1'b0;
  logic rst_n;

  bbr_in_if  in_if();
  bbr_out_if out_if();
  bbr_cfg_if cfg_if();

  box_blur_3x3_rgb_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if),
    .cfg_if (cfg_if)
  );

  // clock, period 4
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // stimulus and expected results
  src_item_t src_items [$];
  blurred_t  blurred_q [$];
  src_item_t tx_cur;
  blurred_t  want;

  // handshake control
  bit in_busy;
  bit no_idle;
  bit rx_hold_req;
  int tx_gap, tx_calm, rx_gap, rx_calm, rx_hold_left;
  int errors;
  int unsigned cycle_count;

  // blur state mirror
  logic [CFG_DATA_W-1:0] reg_width  = CFG_DATA_W'(WIDTH_RESET);
  logic [CFG_DATA_W-1:0] reg_height = CFG_DATA_W'(HEIGHT_RESET);
  bit [PIX_W-1:0] prev2_line [MAX_WIDTH_DEF];
  bit [PIX_W-1:0] prev1_line [MAX_WIDTH_DEF];
  bit [PIX_W-1:0] win [3][3];  // [top..bottom][left..right]
  int unsigned in_x, in_y, out_x, out_y;

  // register value forced into 1..maxv
  function automatic int unsigned usable_dim(logic [CFG_DATA_W-1:0] v, int unsigned maxv);
    int unsigned n;
    n = v;
    if (n == 0) n = 1;
    if (n > maxv) n = maxv;
    return n;
  endfunction

  // back to the start of a frame, line stores untouched
  task automatic frame_rewind();
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) win[i][j] = '0;
    end
    in_x = 0;
    in_y = 0;
    out_x = 0;
    out_y = 0;
  endtask

  // new column enters the window, rows outside the frame read as zero
  task automatic push_column(int unsigned c, int unsigned r, int unsigned h,
                             bit [PIX_W-1:0] pix);
    int unsigned idx;
    bit [PIX_W-1:0] top, mid, bot;
    idx = c % MAX_WIDTH_DEF;
    top = (r >= 2 && r - 2 < h) ? prev2_line[idx] : '0;
    mid = (r >= 1 && r - 1 < h) ? prev1_line[idx] : '0;
    bot = (r < h) ? pix : '0;
    if (r < h) begin
      prev2_line[idx] = prev1_line[idx];
      prev1_line[idx] = pix;
    end
    for (int i = 0; i < 3; i++) begin
      win[i][0] = win[i][1];
      win[i][1] = win[i][2];
    end
    win[0][2] = top;
    win[1][2] = mid;
    win[2][2] = bot;
  endtask

  // per-channel sum over enabled columns, divided by nine
  function automatic bit [PACKED_W-1:0] column_blur(bit [2:0] cols);
    int unsigned sr, sg, sb;
    sr = 0;
    sg = 0;
    sb = 0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        if (cols[2-j]) begin
          sr += win[i][j][23:16];
          sg += win[i][j][15:8];
          sb += win[i][j][7:0];
        end
      end
    end
    return {8'(sr / 9), 8'(sg / 9), 8'(sb / 9), ALPHA};
  endfunction

  // one accepted item through the blur, queueing its result if any
  task automatic blur_step(src_item_t it);
    int unsigned w, h, c, r;
    bit [PACKED_W-1:0] color;
    bit have, last;
    w = usable_dim(reg_width, MAX_WIDTH_DEF);
    h = usable_dim(reg_height, MAX_HEIGHT_DEF);
    if (in_x >= w || in_y > h + 1) frame_rewind();
    c = in_x;
    r = in_y;
    // drain before the frame's last pixel is dropped
    if (r < h && it.op == OP_DRAIN) return;
    have = 1'b0;
    color = '0;
    if (c == 0) begin
      if (r >= 2) begin
        color = column_blur({1'b0, (w >= 2), 1'b1});
        have = 1'b1;
      end
      push_column(0, r, h, it.pix);
    end else begin
      push_column(c, r, h, it.pix);
      if (r >= 1) begin
        color = column_blur({(c >= 2), 1'b1, 1'b1});
        have = 1'b1;
      end
    end
    in_x = c + 1;
    if (in_x >= w) begin
      in_x = 0;
      in_y = r + 1;
    end
    if (have) begin
      last = (out_y == h - 1) && (out_x == w - 1);
      blurred_q.push_back({color, last});
      out_x++;
      if (out_x >= w) begin
        out_x = 0;
        out_y++;
      end
      if (last) frame_rewind();
    end
  endtask

  // input side: take accepted items at the rising edge
  always @(posedge clk) begin
    if (rst_n && in_if.valid && in_if.ready) begin
      blur_step(tx_cur);
      in_busy = 1'b0;
    end
  end

  // input side: offer items at the falling edge, with idle bursts
  always @(negedge clk) begin
    if (!in_busy) begin
      if (tx_gap > 0 && !no_idle) begin
        tx_gap--;
        in_if.valid <= 1'b0;
      end else if (src_items.size() == 0) begin
        in_if.valid <= 1'b0;
      end else if (!no_idle && tx_calm == 0 && $urandom_range(0, 7) == 0) begin
        tx_gap = $urandom_range(0, 16);
        in_if.valid <= 1'b0;
      end else begin
        tx_cur = src_items.pop_front();
        in_if.op <= tx_cur.op;
        in_if.src_red <= tx_cur.pix[23:16];
        in_if.src_green <= tx_cur.pix[15:8];
        in_if.src_blue <= tx_cur.pix[7:0];
        in_if.valid <= 1'b1;
        in_busy = 1'b1;
        if (tx_calm > 0) tx_calm--;
        else if ($urandom_range(0, 31) == 0) tx_calm = $urandom_range(50, 300);
      end
    end
  end

  // output side: ready with bursts of stall and one long hold-off
  always @(negedge clk) begin
    if (rx_hold_req) begin
      rx_hold_left = LONG_STALL;
      rx_hold_req = 1'b0;
    end
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      out_if.ready <= 1'b0;
    end else if (no_idle) begin
      out_if.ready <= 1'b1;
    end else if (rx_gap > 0) begin
      rx_gap--;
      out_if.ready <= 1'b0;
    end else if (rx_calm > 0) begin
      rx_calm--;
      out_if.ready <= 1'b1;
    end else begin
      case ($urandom_range(0, 15))
        0: begin
          rx_gap = $urandom_range(0, 16);
          out_if.ready <= 1'b0;
        end
        1: begin
          rx_calm = $urandom_range(50, 200);
          out_if.ready <= 1'b1;
        end
        default: out_if.ready <= 1'b1;
      endcase
    end
  end

  // output side: compare each result with the oldest expected one
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      if (blurred_q.size() == 0) begin
        $display("%0t: unexpected result: expected none, got colour %08h frame_end %0b",
                 $time, out_if.packed_color, out_if.frame_end);
        errors++;
      end else begin
        want = blurred_q.pop_front();
        if (out_if.packed_color !== want.color) begin
          $display("%0t: colour mismatch: expected %08h, got %08h",
                   $time, want.color, out_if.packed_color);
          errors++;
        end
        if (out_if.frame_end !== want.last) begin
          $display("%0t: frame_end mismatch: expected %0b, got %0b",
                   $time, want.last, out_if.frame_end);
          errors++;
        end
      end
    end
  end

  // cycle limit
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TB_ERROR");
    $finish;
  end

  task automatic push_item(logic op, logic [PIX_W-1:0] pix);
    src_items.push_back({op, pix});
  endtask

  task automatic push_pixels(int unsigned n);
    repeat (n) push_item(OP_PIXEL, PIX_W'($urandom));
  endtask

  // drains, some replaced by pixels that act as drains
  task automatic push_drains(int unsigned n, bit noisy);
    repeat (n) begin
      if (noisy && $urandom_range(0, 3) == 0) push_item(OP_PIXEL, PIX_W'($urandom));
      else push_item(OP_DRAIN, PIX_W'($urandom));
    end
  endtask

  // a whole frame, or one cut short, with optional noise
  task automatic queue_frame(int unsigned w, int unsigned h, bit noisy, bit cut,
                             output int unsigned n);
    int unsigned stop;
    stop = cut ? $urandom_range(1, w * h) : w * h;
    for (int unsigned i = 0; i < stop; i++) begin
      if (noisy && $urandom_range(0, 15) == 0) push_item(OP_DRAIN, PIX_W'($urandom));
      push_item(OP_PIXEL, PIX_W'($urandom));
    end
    n = stop;
    if (!cut) begin
      push_drains(w + 1, noisy);
      n += w + 1;
      if (noisy) repeat ($urandom_range(1, 3)) push_item(OP_DRAIN, PIX_W'($urandom));
    end
  endtask

  // register write, mirrored on acceptance
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned value);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= CFG_DATA_W'(value);
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    if (idx == REG_FRAME_WIDTH) begin
      reg_width = CFG_DATA_W'(value);
      frame_rewind();
    end else if (idx == REG_FRAME_HEIGHT) begin
      reg_height = CFG_DATA_W'(value);
      frame_rewind();
    end
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  // everything sent, every result in, pipeline settled
  task automatic wait_idle();
    while (src_items.size() != 0 || in_busy) @(posedge clk);
    while (blurred_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // main sequence
  initial begin
    int unsigned n, rand_items, w, h;
    bit need_cfg, cut;
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.op = OP_PIXEL;
    in_if.src_red = '0;
    in_if.src_green = '0;
    in_if.src_blue = '0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = REG_FRAME_WIDTH;
    cfg_if.data = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // one line at the width left from reset
    write_reg(REG_FRAME_HEIGHT, 1);
    queue_frame(usable_dim(reg_width, MAX_WIDTH_DEF), 1, 1'b0, 1'b0, n);
    wait_idle();

    // 3x3 frame: early drain, full and empty channels, pixel while draining
    write_reg(REG_FRAME_WIDTH, 3);
    write_reg(REG_FRAME_HEIGHT, 3);
    push_item(OP_DRAIN, 24'h123456);
    for (int i = 0; i < 9; i++) begin
      push_item(OP_PIXEL, {8'hFF, i[0] ? 8'h00 : 8'hFF, i[0] ? 8'hAA : 8'h55});
    end
    push_item(OP_DRAIN, 24'hFFFFFF);
    push_item(OP_DRAIN, 24'h000000);
    push_item(OP_PIXEL, 24'hABCDEF);
    push_item(OP_DRAIN, 24'h000000);
    // extra drains after the frame end
    push_item(OP_DRAIN, 24'h000000);
    push_item(OP_DRAIN, 24'hFFFFFF);
    wait_idle();

    // single pixel frame
    write_reg(REG_FRAME_WIDTH, 1);
    write_reg(REG_FRAME_HEIGHT, 1);
    push_item(OP_PIXEL, 24'h00FF00);
    push_item(OP_DRAIN, 24'hFFFFFF);
    push_item(OP_DRAIN, 24'h000000);
    push_item(OP_DRAIN, 24'h000000);
    wait_idle();

    // spare register index, no effect
    write_reg(REG_SPARE, $urandom_range(0, 2047));

    // width above the maximum, two lines, long output stall and a sender pause
    write_reg(REG_FRAME_WIDTH, 2047);
    write_reg(REG_FRAME_HEIGHT, 2);
    push_pixels(1500);
    rx_hold_req = 1'b1;
    while (src_items.size() != 0 || in_busy) @(posedge clk);
    while (blurred_q.size() != 0) @(posedge clk);
    push_pixels(2 * MAX_WIDTH_DEF - 1500);
    push_drains(MAX_WIDTH_DEF + 1, 1'b0);
    wait_idle();

    // zero width, height above the maximum
    write_reg(REG_FRAME_WIDTH, 0);
    write_reg(REG_FRAME_HEIGHT, 2047);
    push_pixels(MAX_HEIGHT_DEF);
    push_drains(2, 1'b0);
    wait_idle();

    // full width, zero height
    write_reg(REG_FRAME_WIDTH, MAX_WIDTH_DEF);
    write_reg(REG_FRAME_HEIGHT, 0);
    push_pixels(MAX_WIDTH_DEF);
    push_drains(MAX_WIDTH_DEF + 1, 1'b1);
    wait_idle();

    // random small frames, chained or with new sizes, some noisy or cut short
    rand_items = 0;
    need_cfg = 1'b1;
    while (rand_items < RANDOM_ITEMS) begin
      if (rand_items >= RANDOM_ITEMS * 3 / 4) no_idle = 1'b1;
      if (need_cfg || $urandom_range(0, 1) == 0) begin
        wait_idle();
        w = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 12);
        h = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 8);
        case (need_cfg ? 2 : $urandom_range(0, 3))
          0: write_reg(REG_FRAME_WIDTH, w);
          1: write_reg(REG_FRAME_HEIGHT, h);
          default: begin
            write_reg(REG_FRAME_WIDTH, w);
            write_reg(REG_FRAME_HEIGHT, h);
          end
        endcase
      end
      w = usable_dim(reg_width, MAX_WIDTH_DEF);
      h = usable_dim(reg_height, MAX_HEIGHT_DEF);
      cut = ($urandom_range(0, 9) == 0);
      queue_frame(w, h, $urandom_range(0, 2) == 0, cut, n);
      rand_items += n;
      need_cfg = cut;
    end

    // drain out and report
    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### box_blur_3x3_rgb_unit.f
design/bbr_pkg.sv
design/bbr_in_if.sv
design/bbr_out_if.sv
design/bbr_cfg_if.sv
design/bbr_blur_core.sv
design/box_blur_3x3_rgb_unit.sv
tb/box_blur_3x3_rgb_unit_tb.sv
